@@ design/tcgr_pkg.sv @@
// Package for the text cell glyph renderer: word types, register indexes,
// geometry constants, state encoding and palette/pixel packing functions.
// No dependencies.
package tcgr_pkg;

   localparam int GLYPH_COUNT  = 95;
   localparam int GLYPH_HEIGHT = 16;
   localparam int GLYPH_WIDTH  = 8;

   localparam int STORE_DEPTH  = GLYPH_COUNT * GLYPH_HEIGHT;
   localparam int SLOT_W       = $clog2(STORE_DEPTH);
   localparam int GLINE_SH     = $clog2(GLYPH_HEIGHT);
   localparam int COORD_W      = 14;
   localparam int COL_W        = $clog2(GLYPH_WIDTH);

   localparam logic [7:0] FIRST_CODE = 8'h20;
   localparam logic [7:0] LAST_CODE  = 8'h7E;
   localparam logic [7:0] SUBST_CODE = 8'h3F;

   localparam logic [5:0] BPP_32 = 6'd32;
   localparam logic [5:0] BPP_24 = 6'd24;
   localparam logic [5:0] BPP_16 = 6'd16;

   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_RENDER = 1'b1;

   typedef enum logic [2:0] {
      CSR_BASE_ADDRESS   = 3'd0,
      CSR_LINE_PITCH     = 3'd1,
      CSR_SCREEN_WIDTH   = 3'd2,
      CSR_SCREEN_HEIGHT  = 3'd3,
      CSR_BITS_PER_PIXEL = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_PREP,
      ST_PIXEL
   } state_type;

   typedef struct packed {
      logic       req_type;
      logic [9:0] cell_column;
      logic [8:0] cell_line;
      logic [7:0] char_code;
      logic [3:0] fore_index;
      logic [3:0] back_index;
      logic [3:0] glyph_line;
      logic [7:0] font_bits;
   } req_word_type;

   typedef struct packed {
      logic [63:0] byte_address;
      logic [31:0] pixel_data;
      logic [2:0]  byte_count;
      logic        write_valid;
      logic        last_pixel;
   } rsp_word_type;

   typedef struct packed {
      logic [47:0] base_address;
      logic [15:0] line_pitch;
      logic [13:0] screen_width;
      logic [13:0] screen_height;
      logic [5:0]  bits_per_pixel;
   } cfg_type;

   typedef struct packed {
      logic [9:0]         cell_column;
      logic [COORD_W-1:0] pixel_y;
      logic [3:0]         fore_index;
      logic [3:0]         back_index;
   } job_type;

   typedef struct packed {
      logic [31:0] data;
      logic [2:0]  bytes;
   } colour_type;

   // {R, G, B}
   function automatic logic [23:0] vga_rgb(input logic [3:0] idx);
      logic [23:0] rgb;
      unique case (idx)
         4'd0:    rgb = 24'h000000;
         4'd1:    rgb = 24'h0000AA;
         4'd2:    rgb = 24'h00AA00;
         4'd3:    rgb = 24'h00AAAA;
         4'd4:    rgb = 24'hAA0000;
         4'd5:    rgb = 24'hAA00AA;
         4'd6:    rgb = 24'hAA5500;
         4'd7:    rgb = 24'hAAAAAA;
         4'd8:    rgb = 24'h555555;
         4'd9:    rgb = 24'h5555FF;
         4'd10:   rgb = 24'h55FF55;
         4'd11:   rgb = 24'h55FFFF;
         4'd12:   rgb = 24'hFF5555;
         4'd13:   rgb = 24'hFF55FF;
         4'd14:   rgb = 24'hFFFF55;
         default: rgb = 24'hFFFFFF;
      endcase
      return rgb;
   endfunction

   function automatic colour_type pack_colour(input logic [3:0] idx, input logic [5:0] bpp);
      logic [23:0] rgb;
      logic [7:0]  r;
      logic [7:0]  g;
      logic [7:0]  b;
      colour_type  c;
      rgb = vga_rgb(idx);
      r   = rgb[23:16];
      g   = rgb[15:8];
      b   = rgb[7:0];
      if (bpp == BPP_32) begin
         c.data  = {8'hFF, r, g, b};
         c.bytes = 3'd4;
      end else if (bpp == BPP_24) begin
         c.data  = {8'h00, r, g, b};
         c.bytes = 3'd3;
      end else if (bpp == BPP_16) begin
         c.data  = {16'h0000, r[7:3], g[7:2], b[7:3]};
         c.bytes = 3'd2;
      end else begin
         c.data  = 32'h0;
         c.bytes = 3'd0;
      end
      return c;
   endfunction

endpackage

@@ design/text_cell_glyph_renderer_core.sv @@
// Text cell glyph renderer top level: CSRs, request decode, font RAM, pixel sequencer.
// A load word is stored and never raises busy. A render word that yields output
// holds busy through the RAM read, multiply, address add and 8 pixels, so the next
// word is accepted only once busy drops; its eight pixel words are issued one per
// cycle, registered. Sync reset clears CSRs (bits_per_pixel to 32) and the
// sequencer, not the font RAM. No receiver stall.
module text_cell_glyph_renderer_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  tcgr_pkg::req_word_type req_word,
   output logic                   rsp_strobe,
   output tcgr_pkg::rsp_word_type rsp_word,
   input  logic                   csr_write_enable,
   input  tcgr_pkg::csr_index_type csr_index,
   input  logic [47:0]            csr_write_data
);
   import tcgr_pkg::*;

   cfg_type cfg_ff, cfg_in;

   logic               accept;
   logic               printable;
   logic [7:0]         code;
   logic [7:0]         glyph;
   logic               slot_ok;
   logic [SLOT_W-1:0]  slot;
   logic               ready;
   logic               load_en;
   logic               render_en;
   job_type            job;
   logic [7:0]         font_row;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= {48'h0, 16'h0, 14'h0, 14'h0, BPP_32};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_BASE_ADDRESS:   cfg_in.base_address   = csr_write_data;
            CSR_LINE_PITCH:     cfg_in.line_pitch     = csr_write_data[15:0];
            CSR_SCREEN_WIDTH:   cfg_in.screen_width   = csr_write_data[13:0];
            CSR_SCREEN_HEIGHT:  cfg_in.screen_height  = csr_write_data[13:0];
            CSR_BITS_PER_PIXEL: cfg_in.bits_per_pixel = csr_write_data[5:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   assign accept    = start && !busy;
   assign printable = (req_word.char_code >= FIRST_CODE) && (req_word.char_code <= LAST_CODE);
   assign code      = (printable || req_word.req_type == REQ_LOAD) ? req_word.char_code
                                                                    : SUBST_CODE;
   assign glyph     = code - FIRST_CODE;
   assign slot_ok   = ({1'b0, glyph} < 9'(GLYPH_COUNT))
                      && ({2'b0, req_word.glyph_line} < 6'(GLYPH_HEIGHT));
   assign slot      = SLOT_W'({glyph, {GLINE_SH{1'b0}}} + {8'h0, req_word.glyph_line});
   assign ready     = (cfg_ff.base_address != '0) && (cfg_ff.screen_width != '0)
                      && (cfg_ff.screen_height != '0);

   assign load_en   = accept && (req_word.req_type == REQ_LOAD) && printable && slot_ok;
   assign render_en = accept && (req_word.req_type == REQ_RENDER) && ready && slot_ok;

   assign job.cell_column = req_word.cell_column;
   assign job.pixel_y     = COORD_W'({req_word.cell_line, {GLINE_SH{1'b0}}})
                            + COORD_W'(req_word.glyph_line);
   assign job.fore_index  = req_word.fore_index;
   assign job.back_index  = req_word.back_index;

   tcgr_font_ram u_font_ram (
      .clock   (clock),
      .wr_en   (load_en),
      .wr_addr (slot),
      .wr_data (req_word.font_bits),
      .rd_en   (render_en),
      .rd_addr (slot),
      .rd_data (font_row)
   );

   tcgr_pixel_gen u_pixel_gen (
      .clock      (clock),
      .reset      (reset),
      .job_start  (render_en),
      .job        (job),
      .cfg        (cfg_ff),
      .font_row   (font_row),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

endmodule

@@ design/tcgr_font_ram.sv @@
// Font row store: single-port-write, single-port-read synchronous RAM,
// one 8-bit glyph row per entry, registered read. Depends on tcgr_pkg.
module tcgr_font_ram (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [tcgr_pkg::SLOT_W-1:0] wr_addr,
   input  logic [7:0]                 wr_data,
   input  logic                       rd_en,
   input  logic [tcgr_pkg::SLOT_W-1:0] rd_addr,
   output logic [7:0]                 rd_data
);
   import tcgr_pkg::*;

   logic [7:0] mem [STORE_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/tcgr_pixel_gen.sv @@
// Pixel sequencer: takes a fetched glyph row and emits eight pixel write
// words, one per cycle, with a running framebuffer address. Depends on tcgr_pkg.
module tcgr_pixel_gen (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   job_start,
   input  tcgr_pkg::job_type      job,
   input  tcgr_pkg::cfg_type      cfg,
   input  logic [7:0]             font_row,
   output logic                   busy,
   output logic                   rsp_strobe,
   output tcgr_pkg::rsp_word_type rsp_word
);
   import tcgr_pkg::*;

   state_type        state_ff, state_in;
   job_type          job_ff, job_in;
   logic [7:0]       row_ff, row_in;
   logic [29:0]      prod_ff, prod_in;
   logic [48:0]      off_ff, off_in;
   logic [63:0]      addr_ff, addr_in;
   logic [COL_W-1:0] col_ff, col_in;
   rsp_word_type     rsp_ff, rsp_in;
   logic             strobe_ff, strobe_in;

   logic [2:0]         bpb;
   logic [12:0]        x0;
   logic [12:0]        px;
   logic               on;
   colour_type         colour;
   logic               valid;

   assign bpb = cfg.bits_per_pixel[5:3];
   assign x0  = {job_ff.cell_column, {COL_W{1'b0}}};
   assign px  = x0 | {{(13-COL_W){1'b0}}, col_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      row_ff  <= row_in;
      prod_ff <= prod_in;
      off_ff  <= off_in;
      addr_ff <= addr_in;
      col_ff  <= col_in;
      rsp_ff  <= rsp_in;
   end

   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      row_in    = row_ff;
      prod_in   = prod_ff;
      off_in    = off_ff;
      addr_in   = addr_ff;
      col_in    = col_ff;
      rsp_in    = rsp_ff;
      strobe_in = 1'b0;

      on     = row_ff[(GLYPH_WIDTH-1) - col_ff];
      colour = pack_colour(on ? job_ff.fore_index : job_ff.back_index, cfg.bits_per_pixel);
      valid  = (colour.bytes != 3'd0)
               && ({1'b0, px} < cfg.screen_width)
               && (job_ff.pixel_y < cfg.screen_height);

      unique case (state_ff)
         ST_IDLE: begin
            col_in = '0;
            if (job_start) begin
               job_in   = job;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            row_in   = font_row;
            prod_in  = {16'h0, job_ff.pixel_y} * {14'h0, cfg.line_pitch};
            off_in   = {1'b0, cfg.base_address} + {33'h0, 16'(x0 * bpb)};
            state_in = ST_PREP;
         end
         ST_PREP: begin
            addr_in  = {15'h0, off_ff} + {34'h0, prod_ff};
            state_in = ST_PIXEL;
         end
         ST_PIXEL: begin
            strobe_in          = 1'b1;
            rsp_in.last_pixel  = (col_ff == COL_W'(GLYPH_WIDTH-1));
            rsp_in.write_valid = valid;
            rsp_in.byte_address = valid ? addr_ff : 64'h0;
            rsp_in.pixel_data   = valid ? colour.data : 32'h0;
            rsp_in.byte_count   = valid ? colour.bytes : 3'd0;
            addr_in = addr_ff + {61'h0, bpb};
            col_in  = col_ff + 1'b1;
            if (col_ff == COL_W'(GLYPH_WIDTH-1)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_word   = rsp_ff;

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for text_cell_glyph_renderer_core: font loads, glyph-row
// renders and register settings, with a built-in pixel predictor and in-order checker.
// Depends on tcgr_pkg and the core RTL only.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import tcgr_pkg::*;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_word_type req_word;
   logic         rsp_strobe;
   rsp_word_type rsp_word;
   logic         csr_write_enable;
   csr_index_type csr_index;
   logic [47:0]  csr_write_data;

   text_cell_glyph_renderer_core DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_word         (req_word),
      .rsp_strobe       (rsp_strobe),
      .rsp_word         (rsp_word),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   cfg_type      shadow_cfg;
   logic [7:0]   font_rows [STORE_DEPTH];
   bit           row_loaded [STORE_DEPTH];
   rsp_word_type pixel_q [$];
   int           mismatches;
   int           pixels_checked;
   int           renders_sent;
   int           loads_sent;
   int           settings_used;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // {R, G, B}
   function automatic logic [23:0] palette_rgb(input logic [3:0] idx);
      case (idx)
         4'd0:    return 24'h000000;
         4'd1:    return 24'h0000AA;
         4'd2:    return 24'h00AA00;
         4'd3:    return 24'h00AAAA;
         4'd4:    return 24'hAA0000;
         4'd5:    return 24'hAA00AA;
         4'd6:    return 24'hAA5500;
         4'd7:    return 24'hAAAAAA;
         4'd8:    return 24'h555555;
         4'd9:    return 24'h5555FF;
         4'd10:   return 24'h55FF55;
         4'd11:   return 24'h55FFFF;
         4'd12:   return 24'hFF5555;
         4'd13:   return 24'hFF55FF;
         4'd14:   return 24'hFFFF55;
         default: return 24'hFFFFFF;
      endcase
   endfunction

   function automatic logic [31:0] format_colour(input logic [3:0] idx,
                                                 output logic [2:0] nbytes);
      logic [23:0] rgb;
      rgb = palette_rgb(idx);
      nbytes = 3'd0;
      if (shadow_cfg.bits_per_pixel == BPP_32) begin
         nbytes = 3'd4;
         return {8'hFF, rgb};
      end
      if (shadow_cfg.bits_per_pixel == BPP_24) begin
         nbytes = 3'd3;
         return {8'h00, rgb};
      end
      if (shadow_cfg.bits_per_pixel == BPP_16) begin
         nbytes = 3'd2;
         return {16'h0, rgb[23:19], rgb[15:10], rgb[7:3]};
      end
      return 32'h0;
   endfunction

   // -1 when the code has no glyph
   function automatic int glyph_slot(input logic [7:0] code, input logic [3:0] gline);
      if (code < FIRST_CODE || code > LAST_CODE) return -1;
      return (int'(code) - int'(FIRST_CODE)) * GLYPH_HEIGHT + int'(gline);
   endfunction

   function automatic logic [7:0] shown_code(input logic [7:0] code);
      return (code < FIRST_CODE || code > LAST_CODE) ? SUBST_CODE : code;
   endfunction

   function automatic void predict_word(input req_word_type w);
      int           slot;
      logic [7:0]   bits;
      logic [31:0]  fg_data;
      logic [31:0]  bg_data;
      logic [2:0]   fg_bytes;
      logic [2:0]   bg_bytes;
      logic [63:0]  x;
      logic [63:0]  y;
      logic         on;
      rsp_word_type px;
      if (w.req_type == REQ_LOAD) begin
         slot = glyph_slot(w.char_code, w.glyph_line);
         if (slot >= 0) begin
            font_rows[slot]  = w.font_bits;
            row_loaded[slot] = 1'b1;
         end
         return;
      end
      if (shadow_cfg.base_address == '0 || shadow_cfg.screen_width == '0 ||
          shadow_cfg.screen_height == '0) return;
      slot = glyph_slot(shown_code(w.char_code), w.glyph_line);
      if (slot < 0) return;
      bits    = font_rows[slot];
      fg_data = format_colour(w.fore_index, fg_bytes);
      bg_data = format_colour(w.back_index, bg_bytes);
      y = 64'(w.cell_line) * GLYPH_HEIGHT + 64'(w.glyph_line);
      for (int i = 0; i < GLYPH_WIDTH; i++) begin
         x  = 64'(w.cell_column) * GLYPH_WIDTH + 64'(i);
         on = bits[GLYPH_WIDTH - 1 - i];
         px = '0;
         px.byte_count = on ? fg_bytes : bg_bytes;
         if (px.byte_count != 3'd0 && x < 64'(shadow_cfg.screen_width) &&
             y < 64'(shadow_cfg.screen_height)) begin
            px.byte_address = 64'(shadow_cfg.base_address) +
                              y * 64'(shadow_cfg.line_pitch) +
                              x * (64'(shadow_cfg.bits_per_pixel) / 64'd8);
            px.pixel_data   = on ? fg_data : bg_data;
            px.write_valid  = 1'b1;
         end else begin
            px.byte_count = 3'd0;
         end
         px.last_pixel = (i == GLYPH_WIDTH - 1);
         pixel_q.push_back(px);
      end
   endfunction

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_strobe) begin
         if (pixel_q.size() == 0) begin
            $error("unexpected pixel word %h", rsp_word);
            mismatches++;
         end else begin
            want = pixel_q.pop_front();
            pixels_checked++;
            if (rsp_word.byte_address !== want.byte_address) begin
               $error("byte_address expected %h got %h", want.byte_address,
                      rsp_word.byte_address);
               mismatches++;
            end
            if (rsp_word.pixel_data !== want.pixel_data) begin
               $error("pixel_data expected %h got %h", want.pixel_data,
                      rsp_word.pixel_data);
               mismatches++;
            end
            if (rsp_word.byte_count !== want.byte_count) begin
               $error("byte_count expected %0d got %0d", want.byte_count,
                      rsp_word.byte_count);
               mismatches++;
            end
            if (rsp_word.write_valid !== want.write_valid) begin
               $error("write_valid expected %b got %b", want.write_valid,
                      rsp_word.write_valid);
               mismatches++;
            end
            if (rsp_word.last_pixel !== want.last_pixel) begin
               $error("last_pixel expected %b got %b", want.last_pixel,
                      rsp_word.last_pixel);
               mismatches++;
            end
         end
      end
   end

   task automatic send_word(input req_word_type w);
      @(negedge clock);
      start    <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
      predict_word(w);
      if (w.req_type == REQ_LOAD) loads_sent++;
      else renders_sent++;
   endtask

   task automatic idle_for(input int n);
      if (n > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   function automatic int gap_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   // start low, all pixel words back, block idle
   task automatic settle();
      idle_for(1);
      while (pixel_q.size() != 0 || busy) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [47:0] val);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_BASE_ADDRESS:   shadow_cfg.base_address   = val;
         CSR_LINE_PITCH:     shadow_cfg.line_pitch     = val[15:0];
         CSR_SCREEN_WIDTH:   shadow_cfg.screen_width   = val[13:0];
         CSR_SCREEN_HEIGHT:  shadow_cfg.screen_height  = val[13:0];
         CSR_BITS_PER_PIXEL: shadow_cfg.bits_per_pixel = val[5:0];
         default: ;
      endcase
   endtask

   task automatic set_screen(input logic [47:0] base, input logic [47:0] pitch,
                             input logic [47:0] width, input logic [47:0] height,
                             input logic [47:0] bpp);
      settle();
      write_reg(CSR_BASE_ADDRESS, base);
      write_reg(CSR_LINE_PITCH, pitch);
      write_reg(CSR_SCREEN_WIDTH, width);
      write_reg(CSR_SCREEN_HEIGHT, height);
      write_reg(CSR_BITS_PER_PIXEL, bpp);
      settings_used++;
   endtask

   function automatic req_word_type render_word(input logic [7:0] code,
                                                input logic [9:0] col,
                                                input logic [8:0] line,
                                                input logic [3:0] gline,
                                                input logic [3:0] fore,
                                                input logic [3:0] back);
      req_word_type w;
      w             = 48'({$urandom, $urandom});
      w.req_type    = REQ_RENDER;
      w.char_code   = code;
      w.cell_column = col;
      w.cell_line   = line;
      w.glyph_line  = gline;
      w.fore_index  = fore;
      w.back_index  = back;
      return w;
   endfunction

   function automatic logic [9:0] pick_column();
      int hi;
      hi = int'(shadow_cfg.screen_width) / GLYPH_WIDTH;
      if (hi > 1023) hi = 1023;
      if ($urandom_range(0, 3) != 0) return 10'($urandom_range(0, hi));
      return 10'($urandom);
   endfunction

   function automatic logic [8:0] pick_line();
      int hi;
      hi = int'(shadow_cfg.screen_height) / GLYPH_HEIGHT;
      if (hi > 511) hi = 511;
      if ($urandom_range(0, 3) != 0) return 9'($urandom_range(0, hi));
      return 9'($urandom);
   endfunction

   // only rows already loaded are ever rendered
   function automatic req_word_type random_render();
      req_word_type w;
      w = render_word(8'($urandom), pick_column(), pick_line(), 4'($urandom),
                      4'($urandom), 4'($urandom));
      while (!row_loaded[glyph_slot(shown_code(w.char_code), w.glyph_line)]) begin
         w.char_code  = 8'($urandom);
         w.glyph_line = 4'($urandom);
      end
      return w;
   endfunction

   function automatic req_word_type random_load();
      req_word_type w;
      w          = 48'({$urandom, $urandom});
      w.req_type = REQ_LOAD;
      if ($urandom_range(0, 9) < 7)
         w.char_code = 8'($urandom_range(int'(FIRST_CODE), int'(LAST_CODE)));
      return w;
   endfunction

   task automatic run_random(input int count);
      for (int n = 0; n < count; n++) begin
         if (n == count / 2 && $urandom_range(0, 1) == 1) settle();
         if ($urandom_range(0, 4) == 0) send_word(random_load());
         else send_word(random_render());
         // alternate stretches with and without gaps
         if ((n / 20) % 3 != 2) idle_for(gap_cycles());
      end
   endtask

   task automatic load_glyph_set();
      logic [7:0]   glyphs [8];
      req_word_type w;
      glyphs = '{SUBST_CODE, FIRST_CODE, LAST_CODE, 8'h41, 8'h30, 8'h67, 8'h5F, 8'h7C};
      foreach (glyphs[g]) begin
         for (int r = 0; r < GLYPH_HEIGHT; r++) begin
            w            = 48'({$urandom, $urandom});
            w.req_type   = REQ_LOAD;
            w.char_code  = glyphs[g];
            w.glyph_line = 4'(r);
            if (g == 0 && r < 4) begin
               case (r)
                  0: w.font_bits = 8'hFF;
                  1: w.font_bits = 8'h00;
                  2: w.font_bits = 8'hAA;
                  default: w.font_bits = 8'h55;
               endcase
            end
            send_word(w);
            idle_for(gap_cycles());
         end
      end
   endtask

   task automatic test_reset_not_ready();
      settle();
      repeat (4) begin
         send_word(random_render());
         idle_for(gap_cycles());
      end
   endtask

   // bits_per_pixel left at its reset value
   task automatic test_directed();
      logic [7:0]   codes [16];
      req_word_type w;
      logic [7:0]   junk [4];
      settle();
      write_reg(CSR_BASE_ADDRESS, 48'h0000_1000_0000);
      write_reg(CSR_LINE_PITCH, 48'd400);
      write_reg(CSR_SCREEN_WIDTH, 48'd100);
      write_reg(CSR_SCREEN_HEIGHT, 48'd40);
      settings_used++;
      codes = '{8'h3F, 8'h20, 8'h7E, 8'h00, 8'h1F, 8'h7F, 8'h80, 8'hFF,
                8'h41, 8'h30, 8'h67, 8'h5F, 8'h7C, 8'h3F, 8'h41, 8'hC0};
      for (int i = 0; i < 16; i++) begin
         case (i)
            0: w = render_word(codes[i], 10'd0, 9'd0, 4'd0, 4'(i), 4'(15 - i));
            1: w = render_word(codes[i], 10'd1023, 9'd511, 4'd15, 4'(i), 4'(15 - i));
            2: w = render_word(codes[i], 10'd12, 9'd2, 4'd7, 4'(i), 4'(15 - i));
            3: w = render_word(codes[i], 10'd12, 9'd2, 4'd8, 4'(i), 4'(15 - i));
            default: w = render_word(codes[i], 10'($urandom_range(0, 12)),
                                     9'($urandom_range(0, 2)), 4'($urandom),
                                     4'(i), 4'(15 - i));
         endcase
         send_word(w);
         idle_for(i % 4);
      end
      // loads of codes without a glyph change nothing
      junk = '{8'h1F, 8'h7F, 8'h80, 8'hFF};
      foreach (junk[j]) begin
         w            = 48'({$urandom, $urandom});
         w.req_type   = REQ_LOAD;
         w.char_code  = junk[j];
         w.glyph_line = 4'(j);
         w.font_bits  = 8'($urandom);
         send_word(w);
      end
      for (int r = 0; r < 4; r++) begin
         send_word(render_word(SUBST_CODE, 10'd1, 9'd0, 4'(r), 4'd15, 4'd0));
      end
   endtask

   task automatic test_random_32bpp();
      set_screen(48'({$urandom, $urandom}) & 48'hFFFF_FFFF_FFF0 | 48'h10, 48'd3200,
                 48'd800, 48'd600, 48'(BPP_32));
      run_random(40);
   endtask

   // bits_per_pixel written with junk above its six bits
   task automatic test_random_24bpp_extremes();
      set_screen(48'hFFFF_FFFF_FFFF, 48'hFFFF, 48'd8192, 48'd8192, 48'hFFFF_FFFF_FFD8);
      run_random(30);
   endtask

   task automatic test_random_16bpp_tiny();
      set_screen(48'd1, 48'd0, 48'd1, 48'd1, 48'(BPP_16));
      run_random(20);
   endtask

   task automatic test_random_16bpp_mixed();
      set_screen(48'($urandom_range(1, 32'hFFFF_FFFF)), 48'($urandom_range(0, 65535)),
                 48'($urandom_range(1, 8192)), 48'($urandom_range(1, 8192)),
                 48'(BPP_16));
      run_random(30);
   endtask

   task automatic test_unsupported_depth();
      set_screen(48'h0000_0004_0000, 48'd2048, 48'd512, 48'd384, 48'd0);
      run_random(8);
      settle();
      write_reg(CSR_BITS_PER_PIXEL, 48'd8);
      settings_used++;
      run_random(8);
   endtask

   task automatic test_not_ready();
      set_screen(48'd0, 48'd1024, 48'd256, 48'd256, 48'(BPP_32));
      run_random(5);
      set_screen(48'h0000_0000_2000, 48'd1024, 48'd0, 48'd256, 48'(BPP_32));
      run_random(5);
      set_screen(48'h0000_0000_2000, 48'd1024, 48'd256, 48'd0, 48'(BPP_32));
      run_random(5);
      // ready again after the not-ready settings
      set_screen(48'h0000_0000_2000, 48'd1024, 48'd256, 48'd256, 48'(BPP_24));
      run_random(10);
   endtask

   initial begin
      reset            = 1'b1;
      start            = 1'b0;
      req_word         = '0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_BASE_ADDRESS;
      csr_write_data   = '0;
      mismatches       = 0;
      pixels_checked   = 0;
      renders_sent     = 0;
      loads_sent       = 0;
      settings_used    = 0;
      shadow_cfg       = '0;
      shadow_cfg.bits_per_pixel = BPP_32;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      load_glyph_set();
      test_reset_not_ready();
      test_directed();
      test_random_32bpp();
      test_random_24bpp_extremes();
      test_random_16bpp_tiny();
      test_random_16bpp_mixed();
      test_unsupported_depth();
      test_not_ready();

      settle();
      repeat (20) @(posedge clock);
      $display("Covered %0d glyph-row renders and %0d font loads over %0d screen settings,",
               renders_sent, loads_sent, settings_used);
      $display("with %0d pixel words compared field by field.", pixels_checked);
      if (mismatches == 0 && pixel_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         if (pixel_q.size() != 0)
            $error("%0d pixel words never arrived", pixel_q.size());
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

@@ files.f @@
design/tcgr_pkg.sv
design/tcgr_font_ram.sv
design/tcgr_pixel_gen.sv
design/text_cell_glyph_renderer_core.sv
tb/tb_top.sv
